FILE: rtl/html_entity_decoder_unit_assert.svh
// Assertion macros shared by the checker of the entity decoder.
`ifndef HTML_ENTITY_DECODER_UNIT_ASSERT_SVH
`define HTML_ENTITY_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define HEDU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define HEDU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/hedu_pkg.sv
// Types, constants, entity table and UTF-8 helpers of the entity decoder.
package hedu_pkg;

  localparam int NameMax = 16;
  localparam int LenW    = $clog2(NameMax + 1);
  localparam int IdxW    = $clog2(NameMax);
  localparam int CntW    = $clog2(NameMax + 3);
  localparam int CodeW   = 21;
  localparam int TabSize = 39;

  localparam logic [7:0] ChAmp  = 8'h26;
  localparam logic [7:0] ChSemi = 8'h3B;
  localparam logic [7:0] ChHash = 8'h23;
  localparam logic [7:0] ChX    = 8'h78;
  localparam logic [7:0] ChB    = 8'h62;

  localparam logic [CodeW-1:0] CodeMax = 21'h10FFFF;
  localparam logic [CodeW-1:0] CodeCap = 21'h110000;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_PARSE,
    S_EMIT
  } state_e;

  typedef enum logic [2:0] {
    JOB_PASS,
    JOB_LIT,
    JOB_OVF,
    JOB_TAIL,
    JOB_UTF,
    JOB_MARK,
    JOB_PARSE
  } job_e;

  typedef struct packed {
    logic capture;
    logic start;
    job_e job;
    logic code_from_tab;
    logic parse_init;
    logic parse_step;
    logic emit;
    logic set_coll;
    logic clr_coll;
    logic set_ovf;
    logic clr_ovf;
    logic append;
    logic clr_len;
    logic clr_all;
  } cmd_t;

  typedef struct packed {
    logic ovf;
    logic coll;
    logic b_amp;
    logic b_semi;
    logic fin;
    logic len_zero;
    logic len_full;
    logic hash_first;
    logic tab_hit;
    logic parse_done;
    logic code_big;
    logic code_zero;
    logic job_last;
    logic out_free;
  } stat_t;

  // Names are left aligned and padded with zero bytes.
  localparam logic [47:0] TabName [TabSize] = '{
    {"quot", 16'h0}, {"apos", 16'h0}, {"amp", 24'h0}, {"lt", 32'h0},
    {"gt", 32'h0}, {"nbsp", 16'h0}, {"iexcl", 8'h0}, {"cent", 16'h0},
    {"pound", 8'h0}, "curren", {"yen", 24'h0}, "brvbar",
    {"sect", 16'h0}, {"uml", 24'h0}, {"copy", 16'h0}, {"ordf", 16'h0},
    {"laquo", 8'h0}, {"not", 24'h0}, {"shy", 24'h0}, {"reg", 24'h0},
    {"macr", 16'h0}, {"deg", 24'h0}, "plusmn", {"sup2", 16'h0},
    {"sup3", 16'h0}, {"acute", 8'h0}, {"micro", 8'h0}, {"para", 16'h0},
    "middot", {"cedil", 8'h0}, {"sup1", 16'h0}, {"ordm", 16'h0},
    {"raquo", 8'h0}, "frac14", "frac12", "frac34",
    "iquest", {"times", 8'h0}, "divide"
  };

  localparam logic [2:0] TabLen [TabSize] = '{
    3'd4, 3'd4, 3'd3, 3'd2, 3'd2, 3'd4, 3'd5, 3'd4, 3'd5, 3'd6,
    3'd3, 3'd6, 3'd4, 3'd3, 3'd4, 3'd4, 3'd5, 3'd3, 3'd3, 3'd3,
    3'd4, 3'd3, 3'd6, 3'd4, 3'd4, 3'd5, 3'd5, 3'd4, 3'd6, 3'd5,
    3'd4, 3'd4, 3'd5, 3'd6, 3'd6, 3'd6, 3'd6, 3'd5, 3'd6
  };

  localparam logic [7:0] TabCp [TabSize] = '{
    8'h22, 8'h27, 8'h26, 8'h3C, 8'h3E, 8'hA0, 8'hA1, 8'hA2, 8'hA3, 8'hA4,
    8'hA5, 8'hA6, 8'hA7, 8'hA8, 8'hA9, 8'hAA, 8'hAB, 8'hAC, 8'hAD, 8'hAE,
    8'hAF, 8'hB0, 8'hB1, 8'hB2, 8'hB3, 8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB8,
    8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'hBE, 8'hBF, 8'hD7, 8'hF7
  };

  // Returns {hit, code point}; head holds the first six stored name bytes.
  function automatic logic [8:0] tab_lookup(input logic [47:0] head,
                                            input logic [LenW-1:0] len);
    logic [8:0] res;
    logic       match;
    res = '0;
    for (int j = 0; j < TabSize; j++) begin
      match = (len == LenW'(TabLen[j]));
      for (int p = 0; p < 6; p++) begin
        if ((3'(p) < TabLen[j]) && (head[47-8*p -: 8] != TabName[j][47-8*p -: 8])) begin
          match = 1'b0;
        end
      end
      if (match) begin
        res = {1'b1, TabCp[j]};
      end
    end
    return res;
  endfunction

  function automatic logic [2:0] utf_len(input logic [CodeW-1:0] c);
    if (c < 21'h80) return 3'd1;
    else if (c < 21'h800) return 3'd2;
    else if (c < 21'h10000) return 3'd3;
    else return 3'd4;
  endfunction

  function automatic logic [7:0] utf_byte(input logic [CodeW-1:0] c,
                                          input logic [1:0] k);
    logic [7:0] r;
    logic [2:0] n;
    n = utf_len(c);
    r = {2'b10, c[5:0]};
    unique case (n)
      3'd1: r = c[7:0];
      3'd2: if (k == 2'd0) r = {3'b110, c[10:6]};
      3'd3: begin
        if (k == 2'd0) r = {4'b1110, c[15:12]};
        else if (k == 2'd1) r = {2'b10, c[11:6]};
      end
      default: begin
        if (k == 2'd0) r = {5'b11110, c[20:18]};
        else if (k == 2'd1) r = {2'b10, c[17:12]};
        else if (k == 2'd2) r = {2'b10, c[11:6]};
      end
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/hedu_ctrl.sv
// Controller state machine of the entity decoder.
module hedu_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  hedu_pkg::stat_t stat_i,
  output hedu_pkg::cmd_t  cmd_o
);

  hedu_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hedu_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.job  = hedu_pkg::JOB_PASS;
    in_stall_o = (state_q != hedu_pkg::S_IDLE);
    unique case (state_q)
      hedu_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = hedu_pkg::S_DECIDE;
        end
      end
      hedu_pkg::S_DECIDE: begin
        state_d = hedu_pkg::S_EMIT;
        cmd_o.start = 1'b1;
        if (stat_i.ovf) begin
          cmd_o.job = hedu_pkg::JOB_PASS;
          cmd_o.clr_ovf = stat_i.b_semi;
        end else if (!stat_i.coll) begin
          if (stat_i.b_amp) begin
            cmd_o.set_coll = 1'b1;
            cmd_o.clr_len  = 1'b1;
            cmd_o.job      = hedu_pkg::JOB_MARK;
            if (!stat_i.fin) begin
              cmd_o.start = 1'b0;
              state_d     = hedu_pkg::S_IDLE;
            end
          end else begin
            cmd_o.job = hedu_pkg::JOB_PASS;
          end
        end else if (stat_i.b_semi) begin
          cmd_o.clr_coll = 1'b1;
          if (stat_i.len_zero) begin
            cmd_o.job = hedu_pkg::JOB_LIT;
          end else if (stat_i.hash_first) begin
            cmd_o.start      = 1'b0;
            cmd_o.parse_init = 1'b1;
            state_d          = hedu_pkg::S_PARSE;
          end else if (stat_i.tab_hit) begin
            cmd_o.code_from_tab = 1'b1;
            cmd_o.job           = hedu_pkg::JOB_UTF;
          end else begin
            cmd_o.job = hedu_pkg::JOB_LIT;
          end
        end else if (stat_i.len_full) begin
          cmd_o.job      = hedu_pkg::JOB_OVF;
          cmd_o.clr_coll = 1'b1;
          cmd_o.set_ovf  = 1'b1;
        end else begin
          // The stored name is written out at the end of the text.
          cmd_o.append = 1'b1;
          cmd_o.job    = hedu_pkg::JOB_TAIL;
          if (!stat_i.fin) begin
            cmd_o.start = 1'b0;
            state_d     = hedu_pkg::S_IDLE;
          end
        end
      end
      hedu_pkg::S_PARSE: begin
        if (!stat_i.parse_done) begin
          cmd_o.parse_step = 1'b1;
        end else if (stat_i.code_big) begin
          cmd_o.start = 1'b1;
          cmd_o.job   = hedu_pkg::JOB_LIT;
          state_d     = hedu_pkg::S_EMIT;
        end else if (stat_i.code_zero) begin
          cmd_o.clr_len = 1'b1;
          cmd_o.job     = hedu_pkg::JOB_MARK;
          cmd_o.start   = stat_i.fin;
          state_d       = stat_i.fin ? hedu_pkg::S_EMIT : hedu_pkg::S_IDLE;
        end else begin
          cmd_o.start = 1'b1;
          cmd_o.job   = hedu_pkg::JOB_UTF;
          state_d     = hedu_pkg::S_EMIT;
        end
      end
      hedu_pkg::S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.job_last) begin
            cmd_o.clr_len = 1'b1;
            cmd_o.clr_all = stat_i.fin;
            state_d       = hedu_pkg::S_IDLE;
          end
        end
      end
      default: state_d = hedu_pkg::S_IDLE;
    endcase
  end

endmodule

FILE: rtl/hedu_dpath.sv
// Datapath of the entity decoder: name store, number parser and output register.
module hedu_dpath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [7:0]      text_byte_i,
  input  logic            is_final_i,
  input  logic            out_stall_i,
  output logic            out_valid_o,
  output logic [7:0]      out_byte_o,
  output logic            byte_present_o,
  output logic            last_of_run_o,
  output logic            stream_done_o,
  input  hedu_pkg::cmd_t  cmd_i,
  output hedu_pkg::stat_t stat_o
);

  logic [7:0]                  b_q;
  logic                        fin_q;
  logic                        coll_q, ovf_q;
  logic [hedu_pkg::LenW-1:0]   len_q;
  logic [7:0]                  store_q [hedu_pkg::NameMax];
  hedu_pkg::job_e              job_q;
  logic [hedu_pkg::CntW-1:0]   k_q;
  logic [hedu_pkg::CodeW-1:0]  code_q;
  logic [4:0]                  base_q;
  logic                        out_valid_q;

  logic [hedu_pkg::CntW-1:0]   rd_addr;
  logic [7:0]                  rd_byte;
  logic [47:0]                 head;
  logic [8:0]                  tab_res;
  logic [hedu_pkg::CntW-1:0]   job_n;
  logic [7:0]                  emit_byte;
  logic [5:0]                  digit;
  logic                        digit_ok;
  logic [25:0]                 acc;
  logic                        job_last;

  assign head    = {store_q[0], store_q[1], store_q[2], store_q[3], store_q[4], store_q[5]};
  assign tab_res = hedu_pkg::tab_lookup(head, len_q);

  // Literal jobs lead with '&', so their store index is one behind the count.
  assign rd_addr = (job_q == hedu_pkg::JOB_LIT || job_q == hedu_pkg::JOB_OVF) ?
                   k_q - hedu_pkg::CntW'(1) : k_q;
  assign rd_byte = store_q[rd_addr[hedu_pkg::IdxW-1:0]];

  always_comb begin
    unique case (job_q)
      hedu_pkg::JOB_LIT, hedu_pkg::JOB_OVF: job_n = hedu_pkg::CntW'(len_q) + hedu_pkg::CntW'(2);
      hedu_pkg::JOB_TAIL:                   job_n = hedu_pkg::CntW'(len_q);
      hedu_pkg::JOB_UTF:     job_n = hedu_pkg::CntW'(hedu_pkg::utf_len(code_q));
      default:               job_n = hedu_pkg::CntW'(1);
    endcase
  end
  assign job_last = (k_q == job_n - hedu_pkg::CntW'(1));

  always_comb begin
    emit_byte = rd_byte;
    unique case (job_q)
      hedu_pkg::JOB_PASS: emit_byte = b_q;
      hedu_pkg::JOB_LIT, hedu_pkg::JOB_OVF: begin
        if (k_q == '0) begin
          emit_byte = hedu_pkg::ChAmp;
        end else if (k_q == hedu_pkg::CntW'(len_q) + hedu_pkg::CntW'(1)) begin
          emit_byte = (job_q == hedu_pkg::JOB_LIT) ? hedu_pkg::ChSemi : b_q;
        end
      end
      hedu_pkg::JOB_UTF:  emit_byte = hedu_pkg::utf_byte(code_q, k_q[1:0]);
      hedu_pkg::JOB_MARK: emit_byte = 8'h00;
      default:            emit_byte = rd_byte;
    endcase
  end

  // One digit of the numeric reference per cycle.
  always_comb begin
    digit    = 6'd0;
    digit_ok = 1'b0;
    if (base_q == 5'd16) begin
      if (rd_byte >= 8'h30 && rd_byte <= 8'h39) begin
        digit = 6'(rd_byte - 8'h30);
        digit_ok = 1'b1;
      end else if (rd_byte >= 8'h41 && rd_byte <= 8'h5A) begin
        digit = 6'(rd_byte - 8'h41 + 8'd10);
        digit_ok = 1'b1;
      end else if (rd_byte >= 8'h61 && rd_byte <= 8'h7A) begin
        digit = 6'(rd_byte - 8'h61 + 8'd10);
        digit_ok = 1'b1;
      end
    end else if (rd_byte >= 8'h30 && rd_byte < 8'h30 + 8'(base_q)) begin
      digit = 6'(rd_byte - 8'h30);
      digit_ok = 1'b1;
    end
    acc = 26'(code_q) * 26'(base_q) + 26'(digit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coll_q      <= 1'b0;
      ovf_q       <= 1'b0;
      len_q       <= '0;
      job_q       <= hedu_pkg::JOB_PASS;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.set_coll) coll_q <= 1'b1;
      if (cmd_i.clr_coll) coll_q <= 1'b0;
      if (cmd_i.set_ovf)  ovf_q  <= 1'b1;
      if (cmd_i.clr_ovf)  ovf_q  <= 1'b0;
      if (cmd_i.append)   len_q  <= len_q + hedu_pkg::LenW'(1);
      if (cmd_i.clr_len)  len_q  <= '0;
      if (cmd_i.clr_all) begin
        coll_q <= 1'b0;
        ovf_q  <= 1'b0;
        len_q  <= '0;
      end
      if (cmd_i.start) begin
        job_q <= cmd_i.job;
        k_q   <= '0;
      end else if (cmd_i.parse_init) begin
        job_q <= hedu_pkg::JOB_PARSE;
        k_q   <= (len_q >= hedu_pkg::LenW'(2) &&
                  (store_q[1] == hedu_pkg::ChX || store_q[1] == hedu_pkg::ChB)) ?
                 hedu_pkg::CntW'(2) : hedu_pkg::CntW'(1);
      end else if (cmd_i.parse_step || cmd_i.emit) begin
        k_q <= k_q + hedu_pkg::CntW'(1);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      b_q   <= text_byte_i;
      fin_q <= is_final_i;
    end
    if (cmd_i.append) begin
      store_q[len_q[hedu_pkg::IdxW-1:0]] <= b_q;
    end
    if (cmd_i.code_from_tab) begin
      code_q <= hedu_pkg::CodeW'(tab_res[7:0]);
    end else if (cmd_i.parse_init) begin
      code_q <= '0;
      if (len_q >= hedu_pkg::LenW'(2) && store_q[1] == hedu_pkg::ChX) base_q <= 5'd16;
      else if (len_q >= hedu_pkg::LenW'(2) && store_q[1] == hedu_pkg::ChB) base_q <= 5'd2;
      else base_q <= 5'd10;
    end else if (cmd_i.parse_step) begin
      code_q <= (acc > 26'(hedu_pkg::CodeMax)) ? hedu_pkg::CodeCap : acc[hedu_pkg::CodeW-1:0];
    end
    if (cmd_i.emit) begin
      out_byte_o     <= emit_byte;
      byte_present_o <= (job_q != hedu_pkg::JOB_MARK);
      last_of_run_o  <= job_last;
      stream_done_o  <= job_last && fin_q;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    stat_o            = '0;
    stat_o.ovf        = ovf_q;
    stat_o.coll       = coll_q;
    stat_o.b_amp      = (b_q == hedu_pkg::ChAmp);
    stat_o.b_semi     = (b_q == hedu_pkg::ChSemi);
    stat_o.fin        = fin_q;
    stat_o.len_zero   = (len_q == '0);
    stat_o.len_full   = (len_q >= hedu_pkg::LenW'(hedu_pkg::NameMax));
    stat_o.hash_first = (store_q[0] == hedu_pkg::ChHash);
    stat_o.tab_hit    = tab_res[8];
    stat_o.parse_done = (k_q >= hedu_pkg::CntW'(len_q)) || !digit_ok;
    stat_o.code_big   = (code_q > hedu_pkg::CodeMax);
    stat_o.code_zero  = (code_q == '0);
    stat_o.job_last   = job_last;
    stat_o.out_free   = !out_valid_q || !out_stall_i;
  end

endmodule

FILE: rtl/html_entity_decoder_unit.sv
// HTML character entity decoder, top level.
// The input channel takes one text byte per transaction, with is_final_i
// on the last byte of a text. The output channel gives one decoded byte per
// transaction; last_of_run_o marks the last byte caused by an input byte and
// stream_done_o the last byte of the whole text. A final byte that causes no
// output gives one transaction with byte_present_o low.
// A byte is taken, decided on in the next cycle, and its results are then
// loaded into the output register one per cycle while the receiver does
// not stall. A numeric reference adds a digit loop that reads one digit per
// cycle and then finishes. A byte that only extends a name is stored while
// it is decided on and gives no result of its own. The single output
// register lets the next byte be taken while the last result still waits.
// When the receiver stalls, the output register holds and the sequencer
// waits; no result is dropped. Reset clears the entity state and empties the
// output register; stored name bytes are not cleared.
module html_entity_decoder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] text_byte_i,
  input  logic       is_final_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       byte_present_o,
  output logic       last_of_run_o,
  output logic       stream_done_o
);

  hedu_pkg::cmd_t  cmd;
  hedu_pkg::stat_t stat;

  hedu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  hedu_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .text_byte_i    (text_byte_i),
    .is_final_i     (is_final_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .out_byte_o     (out_byte_o),
    .byte_present_o (byte_present_o),
    .last_of_run_o  (last_of_run_o),
    .stream_done_o  (stream_done_o),
    .cmd_i          (cmd),
    .stat_o         (stat)
  );

endmodule

FILE: rtl/hedu_checker.sv
// Port-level checker of the entity decoder and its bind.
`include "html_entity_decoder_unit_assert.svh"

module hedu_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] text_byte_i,
  input logic       is_final_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       byte_present_o,
  input logic       last_of_run_o,
  input logic       stream_done_o
);

  // A stalled result holds its byte.
  `HEDU_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_byte_o))
  // The end of the text always closes a run.
  `HEDU_ASSERT_IMP(a_done_last, out_valid_o && stream_done_o, last_of_run_o)
  // An empty marker is only the final result and carries a zero byte.
  `HEDU_ASSERT_IMP(a_marker, out_valid_o && !byte_present_o,
                   stream_done_o && last_of_run_o && out_byte_o == 8'h00)
  // After a transaction the block is busy deciding.
  `HEDU_ASSERT_NXT(a_busy, in_valid_i && !in_stall_o, in_stall_o)

endmodule

bind html_entity_decoder_unit hedu_checker u_hedu_checker (.*);
